// ===== hdl/ch3d_pkg.sv =====
package ch3d_pkg;

    localparam int INDEX_W = 12;
    localparam int CHAN_W  = 8;
    localparam int CFG_W   = 5;
    localparam int FRAC_W  = 17;
    localparam int QUO_W   = 16;
    localparam int STEP_W  = 4;

    localparam logic [CFG_W-1:0]  BIN_COUNT_RESET = 5'd8;
    localparam logic [FRAC_W-1:0] FRAC_ONE        = 17'h10000;
    localparam logic [FRAC_W-1:0] FRAC_ZERO       = 17'h00000;
    localparam logic [STEP_W-1:0] STEP_LAST       = 4'd15;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUANT,
        ST_ADDR,
        ST_UPDATE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

endpackage

// ===== hdl/ch3d_ram.sv =====
module ch3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/color_histogram_3d_core.sv =====
// Joint blue-green-red color histogram.
// Input channel (in_valid / in_stall): kind 0 is a pixel; each channel is
// quantized to bin_count bins and that cell's counter and the pixel total
// are incremented (saturating). Kind 1 reads cell_index, clears the cell,
// and, with last_read set, clears the pixel total.
// Output channel (out_valid / out_stall): one transfer per read item with
// cell_count, cell_fraction (count/total, unsigned Q1.16, truncated) and
// read_error (index out of range or total zero).
// Items are handled one at a time through a quantize, address, and
// read-modify-write sequence on a single counter RAM with registered reads.
// A pixel passes through the quantize, address and update states. A read
// passes through the same states, then the bit-serial divider when a
// fraction below one has to be computed, then the emit state into the output register.
// The output register holds a result while out_stall is high; pixels are
// still taken meanwhile, and a read waits in its last step for the slot.
// After reset the RAM is swept to zero, one entry per cycle, all
// MAX_BINS**3 entries (4096 by default), with in_stall high. cfg_write_en loads
// bin_count at any time (reset value 8); write it only while idle.
module color_histogram_3d_core #(
    parameter int MAX_BINS    = 16,
    parameter int COUNT_WIDTH = 21
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [ch3d_pkg::CFG_W-1:0]        cfg_write_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [ch3d_pkg::CHAN_W-1:0]       blue,
    input  logic [ch3d_pkg::CHAN_W-1:0]       green,
    input  logic [ch3d_pkg::CHAN_W-1:0]       red,
    input  logic [ch3d_pkg::INDEX_W-1:0]      cell_index,
    input  logic                              last_read,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [COUNT_WIDTH-1:0]            cell_count,
    output logic [ch3d_pkg::FRAC_W-1:0]       cell_fraction,
    output logic                              read_error
);

    import ch3d_pkg::*;

    localparam int CELLS = MAX_BINS * MAX_BINS * MAX_BINS;
    localparam int IDX_W = $clog2(CELLS);
    localparam int BIN_W = $clog2(MAX_BINS + 1);
    localparam int PRD_W = CHAN_W + BIN_W;
    localparam int AW    = 3 * BIN_W;
    localparam int CMP_W = (AW > INDEX_W) ? AW + 1 : INDEX_W + 1;

    localparam logic [IDX_W-1:0]       LAST_CELL = IDX_W'(CELLS - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [BIN_W-1:0]       BINS_MAX  = BIN_W'(MAX_BINS);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]        bin_count_reg;
    logic [BIN_W-1:0]        bins_reg;
    logic [2*BIN_W-1:0]      bsq_reg;
    logic                    kind_reg;
    logic [CHAN_W-1:0]       blue_reg, green_reg, red_reg;
    logic [INDEX_W-1:0]      index_reg;
    logic                    last_reg;
    logic [BIN_W-1:0]        qb_reg, qg_reg, qr_reg;
    logic [IDX_W-1:0]        addr_reg;
    logic                    idx_ok_reg;
    logic [IDX_W-1:0]        clr_addr_reg;
    logic [COUNT_WIDTH-1:0]  total_reg;
    logic [COUNT_WIDTH-1:0]  den_reg;
    logic [COUNT_WIDTH-1:0]  rem_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [COUNT_WIDTH-1:0]  res_count_reg;
    logic [FRAC_W-1:0]       res_frac_reg;
    logic                    res_err_reg;
    logic                    out_valid_reg;
    logic [COUNT_WIDTH-1:0]  out_count_reg;
    logic [FRAC_W-1:0]       out_frac_reg;
    logic                    out_err_reg;

    logic                    in_xfer;
    logic                    out_load;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [COUNT_WIDTH-1:0]  mem_wdata;
    logic [IDX_W-1:0]        mem_raddr;
    logic [COUNT_WIDTH-1:0]  mem_rdata;

    logic [BIN_W-1:0]        bins_used;
    logic [PRD_W-1:0]        prod_b, prod_g, prod_r;
    logic [AW-1:0]           addr_full;
    logic [AW-1:0]           cells_used;
    logic                    idx_ok;
    logic [COUNT_WIDTH-1:0]  count_inc;
    logic [COUNT_WIDTH-1:0]  total_inc;
    logic                    total_zero;
    logic                    frac_sat;
    logic [COUNT_WIDTH:0]    rem_shift;
    logic                    rem_ge;
    logic [COUNT_WIDTH:0]    rem_sub;

    ch3d_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (CELLS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // bins clamp: 0 acts as 1, above MAX_BINS acts as MAX_BINS
    always_comb
    begin
        if (bin_count_reg == '0)
        begin
            bins_used = BIN_W'(1);
        end
        else if (CFG_W'(bin_count_reg) > CFG_W'(MAX_BINS))
        begin
            bins_used = BINS_MAX;
        end
        else
        begin
            bins_used = BIN_W'(bin_count_reg);
        end
    end

    assign prod_b = PRD_W'(blue_reg)  * PRD_W'(bins_reg);
    assign prod_g = PRD_W'(green_reg) * PRD_W'(bins_reg);
    assign prod_r = PRD_W'(red_reg)   * PRD_W'(bins_reg);

    assign addr_full  = AW'(qb_reg) * AW'(bsq_reg) + AW'(qg_reg) * AW'(bins_reg) + AW'(qr_reg);
    assign cells_used = AW'(bsq_reg) * AW'(bins_reg);
    assign idx_ok     = (CMP_W'(index_reg) < CMP_W'(cells_used))
                     && (CMP_W'(index_reg) < CMP_W'(CELLS));

    assign count_inc  = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + 1'b1;
    assign total_inc  = (total_reg == COUNT_MAX) ? total_reg : total_reg + 1'b1;
    assign total_zero = (total_reg == '0);
    assign frac_sat   = (mem_rdata >= total_reg);

    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_QUANT;
                end
            end
            ST_QUANT:
            begin
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                priority if (kind_reg == KIND_PIXEL)
                begin
                    state_next = ST_IDLE;
                end
                else if (!idx_ok_reg || total_zero || frac_sat)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall  = 1'b1;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        mem_raddr = addr_full[IDX_W-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_ADDR:
            begin
                if (kind_reg == KIND_READ)
                begin
                    mem_raddr = index_reg[IDX_W-1:0];
                end
            end
            ST_UPDATE:
            begin
                if (kind_reg == KIND_PIXEL)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = count_inc;
                end
                else
                begin
                    mem_we = idx_ok_reg;
                end
            end
            ST_EMIT:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign in_xfer = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            bin_count_reg <= BIN_COUNT_RESET;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_write_en)
            begin
                bin_count_reg <= cfg_write_data;
            end
            if (state_reg == ST_UPDATE)
            begin
                if (kind_reg == KIND_PIXEL)
                begin
                    total_reg <= total_inc;
                end
                else if (last_reg)
                begin
                    total_reg <= '0;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg  <= kind;
            blue_reg  <= blue;
            green_reg <= green;
            red_reg   <= red;
            index_reg <= cell_index;
            last_reg  <= last_read;
            bins_reg  <= bins_used;
        end
        if (state_reg == ST_QUANT)
        begin
            qb_reg  <= prod_b[PRD_W-1:CHAN_W];
            qg_reg  <= prod_g[PRD_W-1:CHAN_W];
            qr_reg  <= prod_r[PRD_W-1:CHAN_W];
            bsq_reg <= (2*BIN_W)'(bins_reg) * (2*BIN_W)'(bins_reg);
        end
        if (state_reg == ST_ADDR)
        begin
            addr_reg   <= (kind_reg == KIND_READ) ? index_reg[IDX_W-1:0]
                                                  : addr_full[IDX_W-1:0];
            idx_ok_reg <= idx_ok;
        end
        if (state_reg == ST_UPDATE)
        begin
            den_reg      <= total_reg;
            rem_reg      <= mem_rdata;
            step_reg     <= '0;
            res_count_reg <= idx_ok_reg ? mem_rdata : '0;
            res_err_reg  <= !idx_ok_reg || total_zero;
            res_frac_reg <= (idx_ok_reg && !total_zero && frac_sat) ? FRAC_ONE : FRAC_ZERO;
        end
        if (state_reg == ST_DIVIDE)
        begin
            rem_reg      <= rem_ge ? rem_sub[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
            res_frac_reg <= {res_frac_reg[FRAC_W-2:0], rem_ge};
            step_reg     <= step_reg + 1'b1;
        end
        if (out_load)
        begin
            out_count_reg <= res_count_reg;
            out_frac_reg  <= res_frac_reg;
            out_err_reg   <= res_err_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cell_count    = out_count_reg;
    assign cell_fraction = out_frac_reg;
    assign read_error    = out_err_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_QUANT))
        else $error("transfer accepted outside idle");

    a_ram_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_UPDATE))
        else $error("counter RAM written outside update or clear");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_err_frac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && read_error) |-> (cell_fraction == FRAC_ZERO))
        else $error("error result carries a fraction");

endmodule

// ===== tb/sv/color_histogram_3d_core_tb.sv =====
`timescale 1ns / 100ps

module color_histogram_3d_core_tb;

    import ch3d_pkg::*;

    localparam int MAX_BINS       = 16;
    localparam int COUNT_W        = 21;
    localparam int CELL_TOTAL     = MAX_BINS * MAX_BINS * MAX_BINS;
    localparam longint COUNT_MAX  = (64'd1 << COUNT_W) - 1;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PRINT_LIMIT    = 50;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [FRAC_W-1:0]  fraction;
        logic               error;
    } cell_read_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_W-1:0]     cfg_write_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 kind;
    logic [CHAN_W-1:0]    blue;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    red;
    logic [INDEX_W-1:0]   cell_index;
    logic                 last_read;
    logic                 out_valid;
    logic                 out_stall;
    logic [COUNT_W-1:0]   cell_count;
    logic [FRAC_W-1:0]    cell_fraction;
    logic                 read_error;

    // predicted histogram state
    logic [COUNT_W-1:0]   cell_store [CELL_TOTAL];
    logic [COUNT_W-1:0]   pixel_sum;
    logic [CFG_W-1:0]     bin_setting;
    int unsigned          hit_cells [$];
    cell_read_t           pending_reads [$];
    cell_read_t           oldest_read;

    int                   error_count;
    int unsigned          items_sent;
    int                   burst_left;
    int                   idle_cycles;
    bit                   hold_request;

    color_histogram_3d_core #(
        .MAX_BINS    (MAX_BINS),
        .COUNT_WIDTH (COUNT_W)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .blue           (blue),
        .green          (green),
        .red            (red),
        .cell_index     (cell_index),
        .last_read      (last_read),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_count     (cell_count),
        .cell_fraction  (cell_fraction),
        .read_error     (read_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned bins_used(input logic [CFG_W-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > MAX_BINS)
            return MAX_BINS;
        return int'(setting);
    endfunction

    function automatic logic [CHAN_W-1:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < PRINT_LIMIT)
            $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic histogram_predict(input logic k, input logic [CHAN_W-1:0] b,
                                     input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] r,
                                     input logic [INDEX_W-1:0] idx, input logic lst);
        int unsigned nb;
        int unsigned flat;
        longint      quotient;
        cell_read_t  res;
        nb = bins_used(bin_setting);
        if (k == KIND_PIXEL)
        begin
            flat = (((b * nb) >> 8) * nb + ((g * nb) >> 8)) * nb + ((r * nb) >> 8);
            if (cell_store[flat] != COUNT_MAX)
                cell_store[flat]++;
            if (pixel_sum != COUNT_MAX)
                pixel_sum++;
            hit_cells.insert(hit_cells.size(), flat);
        end
        else
        begin
            res = '0;
            if (idx >= nb * nb * nb)
                res.error = 1'b1;
            else
            begin
                res.count = cell_store[idx];
                cell_store[idx] = '0;
                if (pixel_sum == 0)
                    res.error = 1'b1;
                else
                begin
                    quotient = (longint'(res.count) << 16) / longint'(pixel_sum);
                    res.fraction = (quotient > FRAC_ONE) ? FRAC_ONE : FRAC_W'(quotient);
                end
            end
            if (lst)
                pixel_sum = '0;
            pending_reads.insert(pending_reads.size(), res);
        end
    endtask

    // called at a falling edge; returns at a falling edge with valid possibly still high
    task automatic send_item(input logic k, input logic [CHAN_W-1:0] b,
                             input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] r,
                             input logic [INDEX_W-1:0] idx, input logic lst);
        int gap;
        kind       = k;
        blue       = b;
        green      = g;
        red        = r;
        cell_index = idx;
        last_read  = lst;
        in_valid   = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        histogram_predict(k, b, g, r, idx, lst);
        items_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(10, 40);
        end
    endtask

    task automatic send_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] r);
        send_item(KIND_PIXEL, b, g, r, INDEX_W'($urandom_range(0, 4095)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_read(input logic [INDEX_W-1:0] idx, input logic lst);
        send_item(KIND_READ, rand_channel(), rand_channel(), rand_channel(), idx, lst);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_bins(input logic [CFG_W-1:0] value);
        cfg_write_en   = 1'b1;
        cfg_write_data = value;
        bin_setting    = value;
        @(negedge clk);
        cfg_write_en   = 1'b0;
    endtask

    task automatic test_extremes();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd128, 8'd64, 8'd255);
        send_read(12'd0, 1'b0);
        send_read(12'd511, 1'b0);
        send_read(12'd512, 1'b0);
        send_read(12'd4095, 1'b1);
    endtask

    task automatic test_zero_total();
        send_read(12'd279, 1'b0);
        send_read(12'd279, 1'b0);
    endtask

    task automatic test_fraction_saturation();
        repeat (3) send_pixel(8'd10, 8'd10, 8'd10);
        send_read(12'd1, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_read(12'd0, 1'b0);
        send_read(12'd511, 1'b1);
    endtask

    task automatic test_bin_limits();
        wait_idle();
        write_bins(5'd0);
        send_pixel(rand_channel(), rand_channel(), rand_channel());
        send_read(12'd1, 1'b0);
        send_read(12'd0, 1'b1);
        wait_idle();
        write_bins(5'd31);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_read(12'd4095, 1'b1);
    endtask

    task automatic test_bin_change();
        wait_idle();
        write_bins(5'd8);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd17, 8'd200, 8'd99);
        wait_idle();
        write_bins(5'd16);
        send_read(12'd511, 1'b1);
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        send_read(12'd0, 1'b0);
        repeat (12) send_pixel(rand_channel(), rand_channel(), rand_channel());
        send_read(INDEX_W'(hit_cells[hit_cells.size()-1]), 1'b0);
        send_read(12'd0, 1'b1);
    endtask

    function automatic logic [INDEX_W-1:0] pick_read_index(input int unsigned nb);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6 && hit_cells.size() > 0)
            return INDEX_W'(hit_cells[$urandom_range(0, hit_cells.size() - 1)]);
        if (sel < 9)
            return INDEX_W'($urandom_range(0, nb * nb * nb - 1));
        return INDEX_W'($urandom_range(0, 4095));
    endfunction

    task automatic test_random_images();
        logic [CFG_W-1:0] sweep [10];
        int unsigned      start;
        int               phase;
        int               n_pix;
        int               n_read;
        sweep = '{5'd2, 5'd16, 5'd0, 5'd7, 5'd31, 5'd1, 5'd12, 5'd8, 5'd3, 5'd16};
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            wait_idle();
            write_bins((phase < 10) ? sweep[phase] : CFG_W'($urandom_range(0, 31)));
            hit_cells.delete();
            repeat ($urandom_range(1, 2))
            begin
                n_pix = $urandom_range(10, 120);
                repeat (n_pix)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_read(pick_read_index(bins_used(bin_setting)),
                                  $urandom_range(0, 7) == 0);
                    else
                        send_pixel(rand_channel(), rand_channel(), rand_channel());
                end
                n_read = $urandom_range(6, 24);
                for (int i = 0; i < n_read; i++)
                    send_read(pick_read_index(bins_used(bin_setting)),
                              (i == n_read - 1) && ($urandom_range(0, 4) != 0));
            end
            phase++;
        end
    endtask

    // receiver: stall pattern in random modes, with one long hold on request
    initial
    begin
        int mode;
        int left;
        out_stall = 1'b0;
        left = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                out_stall = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(10, 80);
                end
                left--;
                case (mode)
                    0:       out_stall = 1'b0;
                    1:       out_stall = ($urandom_range(0, 3) == 0);
                    default: out_stall = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reads.size() == 0)
                report_mismatch("result with nothing pending, cell_count", cell_count, 0);
            else
            begin
                oldest_read = pending_reads.pop_front();
                if (cell_count !== oldest_read.count)
                    report_mismatch("cell_count", cell_count, oldest_read.count);
                if (cell_fraction !== oldest_read.fraction)
                    report_mismatch("cell_fraction", cell_fraction, oldest_read.fraction);
                if (read_error !== oldest_read.error)
                    report_mismatch("read_error", read_error, oldest_read.error);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("color_histogram_3d_core_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        kind           = KIND_PIXEL;
        blue           = '0;
        green          = '0;
        red            = '0;
        cell_index     = '0;
        last_read      = 1'b0;
        error_count    = 0;
        items_sent     = 0;
        idle_cycles    = 0;
        hold_request   = 1'b0;
        burst_left     = $urandom_range(1, 20);
        bin_setting    = BIN_COUNT_RESET;
        pixel_sum      = '0;
        foreach (cell_store[i])
            cell_store[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_zero_total();
        test_fraction_saturation();
        test_bin_limits();
        test_bin_change();
        test_backpressure();
        test_random_images();
        wait_idle();

        if (error_count == 0)
            $display("color_histogram_3d_core_tb: clean");
        else
            $display("color_histogram_3d_core_tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ch3d_pkg.sv
hdl/ch3d_ram.sv
hdl/color_histogram_3d_core.sv
tb/sv/color_histogram_3d_core_tb.sv
